// File: rtl/mqttd_pkg.sv
// Shared types, codes and constants of the MQTT receive deframer.
// No dependencies; used by every rtl file and by the checker.
package mqttd_pkg;

    localparam int unsigned LEN_W       = 28;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Reset value of the remaining length limit (8 MiB)
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 28'd8388608;

    // Byte roles
    localparam logic [2:0] ROLE_FIXED   = 3'd0;
    localparam logic [2:0] ROLE_LENGTH  = 3'd1;
    localparam logic [2:0] ROLE_VARHDR  = 3'd2;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd3;
    localparam logic [2:0] ROLE_DISCARD = 3'd4;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
    localparam logic [1:0] ERR_MALFORMED = 2'd2;
    localparam logic [1:0] ERR_BAD_TYPE  = 2'd3;

    // Control packet types
    localparam logic [3:0] PKT_NONE     = 4'd0;
    localparam logic [3:0] PKT_CONNACK  = 4'd2;
    localparam logic [3:0] PKT_PUBLISH  = 4'd3;
    localparam logic [3:0] PKT_PUBACK   = 4'd4;
    localparam logic [3:0] PKT_PUBREC   = 4'd5;
    localparam logic [3:0] PKT_PUBREL   = 4'd6;
    localparam logic [3:0] PKT_PUBCOMP  = 4'd7;
    localparam logic [3:0] PKT_SUBACK   = 4'd9;
    localparam logic [3:0] PKT_UNSUBACK = 4'd11;
    localparam logic [3:0] PKT_PINGREQ  = 4'd12;
    localparam logic [3:0] PKT_PINGRESP = 4'd13;

    // One classified byte as it travels from the front to the back
    typedef struct packed {
        logic [7:0] data;
        logic       more;     // continuation bit of a length byte
        logic [6:0] group;    // 7-bit length group
        logic [3:0] nibble;   // type field if this is a fixed header
        logic [1:0] qos;      // qos field if this is a fixed header
    } entry_t;

endpackage

// File: rtl/mqttd_front.sv
// Input side of the deframer: accepts bytes and splits them into fields.
// Depends on mqttd_pkg; feeds the queue.
module mqttd_front
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        rx_byte,
    output logic              push_valid,
    input  logic              push_ready,
    output mqttd_pkg::entry_t push_data
);

    // Pass the handshake through to the queue
    assign push_valid = in_valid;
    assign in_ready   = push_ready;

    // Split the byte into the fields each role needs
    always_comb
    begin
        push_data.data   = rx_byte;
        push_data.more   = rx_byte[7];
        push_data.group  = rx_byte[6:0];
        push_data.nibble = rx_byte[7:4];
        push_data.qos    = rx_byte[2:1];
    end

endmodule

// File: rtl/mqttd_queue.sv
// Short queue of classified bytes between the front and the back.
// Depends on mqttd_pkg for the entry type.
module mqttd_queue #(
    parameter int unsigned DEPTH = mqttd_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  mqttd_pkg::entry_t push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output mqttd_pkg::entry_t pop_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    mqttd_pkg::entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != CNT_MAX);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/mqttd_back.sv
// Packet parser and result register of the deframer.
// Depends on mqttd_pkg; takes classified bytes from the queue.
module mqttd_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [mqttd_pkg::LEN_W-1:0]    cfg_write_data,
    input  logic                           pop_valid,
    output logic                           pop_ready,
    input  mqttd_pkg::entry_t              pop_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     data_byte,
    output logic [2:0]                     byte_role,
    output logic [3:0]                     packet_type,
    output logic [1:0]                     qos_level,
    output logic [mqttd_pkg::LEN_W-1:0]    remaining_length,
    output logic                           end_of_packet,
    output logic [15:0]                    packet_id,
    output logic                           packet_id_valid,
    output logic [3:0]                     reply_type,
    output logic [1:0]                     fault_code
);

    localparam int unsigned LEN_W = mqttd_pkg::LEN_W;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [16:0] POS_MAX = 17'h1FFFF;

    function automatic logic is_ack(input logic [3:0] t);
        is_ack = (t == mqttd_pkg::PKT_PUBACK)  || (t == mqttd_pkg::PKT_PUBREC) ||
                 (t == mqttd_pkg::PKT_PUBREL)  || (t == mqttd_pkg::PKT_PUBCOMP) ||
                 (t == mqttd_pkg::PKT_SUBACK)  || (t == mqttd_pkg::PKT_UNSUBACK);
    endfunction

    function automatic logic is_handled(input logic [3:0] t);
        is_handled = (t inside {[mqttd_pkg::PKT_CONNACK:mqttd_pkg::PKT_PUBCOMP]}) ||
                     (t == mqttd_pkg::PKT_SUBACK) ||
                     (t inside {[mqttd_pkg::PKT_UNSUBACK:mqttd_pkg::PKT_PINGRESP]});
    endfunction

    // Place a 7-bit group at its weight in the length
    function automatic logic [LEN_W-1:0] place_group(input logic [6:0] g,
                                                     input logic [1:0] idx);
        case (idx)
            2'd0:    place_group = {21'd0, g};
            2'd1:    place_group = {14'd0, g, 7'd0};
            2'd2:    place_group = {7'd0, g, 14'd0};
            2'd3:    place_group = {g, 21'd0};
            default: place_group = '0;
        endcase
    endfunction

    typedef struct packed {
        logic [7:0]       data;
        logic [2:0]       role;
        logic [3:0]       ptype;
        logic [1:0]       qos;
        logic [LEN_W-1:0] rlen;
        logic             eop;
        logic [15:0]      id;
        logic             id_valid;
        logic [3:0]       reply;
        logic [1:0]       err;
    } result_t;

    logic [LEN_W-1:0] max_len_reg;
    logic [1:0]       phase_reg, phase_next;
    logic [LEN_W-1:0] len_acc_reg, len_acc_next;
    logic [2:0]       len_cnt_reg, len_cnt_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [3:0]       type_reg, type_next;
    logic [1:0]       qos_reg, qos_next;
    logic [15:0]      topic_reg, topic_next;
    logic [16:0]      pos_reg, pos_next;
    logic [15:0]      id_reg, id_next;
    logic             halted_reg, halted_next;
    logic             out_valid_reg;
    result_t          res_reg, res;
    logic             take;
    logic [16:0]      topic_end;
    logic             id_done;

    assign pop_ready = !out_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;
    assign topic_end = {1'b0, topic_reg} + 17'd2;

    // Parse one byte: next state and its result
    always_comb
    begin
        phase_next  = phase_reg;
        len_acc_next = len_acc_reg;
        len_cnt_next = len_cnt_reg;
        left_next   = left_reg;
        type_next   = type_reg;
        qos_next    = qos_reg;
        topic_next  = topic_reg;
        pos_next    = pos_reg;
        id_next     = id_reg;
        halted_next = halted_reg;
        res         = '0;
        res.data    = pop_data.data;
        res.role    = mqttd_pkg::ROLE_DISCARD;

        if (!halted_reg)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    res.role     = mqttd_pkg::ROLE_FIXED;
                    type_next    = pop_data.nibble;
                    qos_next     = pop_data.qos;
                    len_acc_next = '0;
                    len_cnt_next = '0;
                    left_next    = '0;
                    topic_next   = '0;
                    pos_next     = '0;
                    id_next      = '0;
                    phase_next   = PH_LENGTH;
                end
                PH_LENGTH:
                begin
                    res.role = mqttd_pkg::ROLE_LENGTH;
                    if (len_cnt_reg[2])
                    begin
                        res.err     = mqttd_pkg::ERR_MALFORMED;
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        len_acc_next = len_acc_reg |
                                       place_group(pop_data.group, len_cnt_reg[1:0]);
                        len_cnt_next = len_cnt_reg + 3'd1;
                        if (!pop_data.more)
                        begin
                            if (len_acc_next > max_len_reg)
                            begin
                                res.err     = mqttd_pkg::ERR_TOO_LONG;
                                halted_next = 1'b1;
                            end
                            else if (len_acc_next == '0)
                            begin
                                res.eop = 1'b1;
                            end
                            else
                            begin
                                left_next  = len_acc_next;
                                phase_next = PH_BODY;
                            end
                        end
                    end
                end
                PH_BODY:
                begin
                    res.role = mqttd_pkg::ROLE_PAYLOAD;
                    if (type_reg == mqttd_pkg::PKT_PUBLISH)
                    begin
                        if (pos_reg < 17'd2)
                        begin
                            res.role = mqttd_pkg::ROLE_VARHDR;
                            if (pos_reg == 17'd0)
                            begin
                                topic_next = {pop_data.data, 8'd0};
                            end
                            else
                            begin
                                topic_next = topic_reg | {8'd0, pop_data.data};
                            end
                        end
                        else if (pos_reg < topic_end)
                        begin
                            res.role = mqttd_pkg::ROLE_VARHDR;
                        end
                        else if (qos_reg != 2'd0 && pos_reg < topic_end + 17'd2)
                        begin
                            res.role = mqttd_pkg::ROLE_VARHDR;
                            if (pos_reg == topic_end)
                            begin
                                id_next = {pop_data.data, 8'd0};
                            end
                            else
                            begin
                                id_next = id_reg | {8'd0, pop_data.data};
                            end
                        end
                    end
                    else if (is_ack(type_reg))
                    begin
                        if (pos_reg < 17'd2)
                        begin
                            res.role = mqttd_pkg::ROLE_VARHDR;
                            if (pos_reg == 17'd0)
                            begin
                                id_next = {pop_data.data, 8'd0};
                            end
                            else
                            begin
                                id_next = id_reg | {8'd0, pop_data.data};
                            end
                        end
                    end
                    else if (type_reg == mqttd_pkg::PKT_CONNACK)
                    begin
                        if (pos_reg < 17'd2)
                        begin
                            res.role = mqttd_pkg::ROLE_VARHDR;
                        end
                    end
                    pos_next  = (pos_reg < POS_MAX) ? pos_reg + 17'd1 : POS_MAX;
                    left_next = (left_reg != '0) ? left_reg - 1'b1 : '0;
                    if (left_next == '0)
                    begin
                        res.eop = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            // Close the packet: owed reply or unexpected type
            if (res.eop)
            begin
                if (!is_handled(type_next))
                begin
                    res.err     = mqttd_pkg::ERR_BAD_TYPE;
                    halted_next = 1'b1;
                end
                else
                begin
                    phase_next = PH_HEADER;
                    case (type_next)
                        mqttd_pkg::PKT_PUBLISH:
                        begin
                            if (qos_next == 2'd1)
                            begin
                                res.reply = mqttd_pkg::PKT_PUBACK;
                            end
                            else if (qos_next == 2'd2)
                            begin
                                res.reply = mqttd_pkg::PKT_PUBREC;
                            end
                        end
                        mqttd_pkg::PKT_PUBREC:  res.reply = mqttd_pkg::PKT_PUBREL;
                        mqttd_pkg::PKT_PUBREL:  res.reply = mqttd_pkg::PKT_PUBCOMP;
                        mqttd_pkg::PKT_PINGREQ: res.reply = mqttd_pkg::PKT_PINGRESP;
                        default:                res.reply = mqttd_pkg::PKT_NONE;
                    endcase
                end
            end

            res.ptype = type_next;
            res.qos   = qos_next;
            res.rlen  = (res.role == mqttd_pkg::ROLE_FIXED) ? '0 : len_acc_next;
            if (res.role != mqttd_pkg::ROLE_FIXED && id_done)
            begin
                res.id       = id_next;
                res.id_valid = 1'b1;
            end
        end
    end

    // Identifier is complete once both of its bytes are in
    always_comb
    begin
        id_done = 1'b0;
        if (type_next == mqttd_pkg::PKT_PUBLISH)
        begin
            id_done = (qos_next != 2'd0) && (pos_next >= 17'd2) &&
                      (pos_next >= {1'b0, topic_next} + 17'd4);
        end
        else if (is_ack(type_next))
        begin
            id_done = (pos_next >= 17'd2);
        end
    end

    // Hold the limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= mqttd_pkg::MAX_LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            max_len_reg <= cfg_write_data;
        end
    end

    // Advance parser state on each taken byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            len_acc_reg <= '0;
            len_cnt_reg <= '0;
            left_reg    <= '0;
            type_reg    <= '0;
            qos_reg     <= '0;
            topic_reg   <= '0;
            pos_reg     <= '0;
            id_reg      <= '0;
            halted_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            len_acc_reg <= len_acc_next;
            len_cnt_reg <= len_cnt_next;
            left_reg    <= left_next;
            type_reg    <= type_next;
            qos_reg     <= qos_next;
            topic_reg   <= topic_next;
            pos_reg     <= pos_next;
            id_reg      <= id_next;
            halted_reg  <= halted_next;
        end
    end

    // Output register: load on take, drop when delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res;
        end
    end

    assign out_valid        = out_valid_reg;
    assign data_byte        = res_reg.data;
    assign byte_role        = res_reg.role;
    assign packet_type      = res_reg.ptype;
    assign qos_level        = res_reg.qos;
    assign remaining_length = res_reg.rlen;
    assign end_of_packet    = res_reg.eop;
    assign packet_id        = res_reg.id;
    assign packet_id_valid  = res_reg.id_valid;
    assign reply_type       = res_reg.reply;
    assign fault_code       = res_reg.err;

endmodule

// File: rtl/mqtt_rx_packet_deframer_unit.sv
// Byte-serial MQTT receive deframer: one result per byte, one byte per clock
// sustained when the output is not stalled. A byte is classified in the front,
// waits in a queue of QUEUE_DEPTH entries, and is parsed by the back, whose
// result is registered and on the outputs in the cycle after the back takes
// the byte. The rate is set by the parse step in the back unit. The limit
// register resets to 8388608 and the user must write it only while idle,
// through cfg_write_en/cfg_write_data; the block itself does not enforce it.
// After any error every following byte comes out as discarded until reset.
// Depends on mqttd_pkg, mqttd_front, mqttd_queue and mqttd_back.
module mqtt_rx_packet_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = mqttd_pkg::QUEUE_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  logic [mqttd_pkg::LEN_W-1:0] cfg_write_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  rx_byte,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  data_byte,
    output logic [2:0]                  byte_role,
    output logic [3:0]                  packet_type,
    output logic [1:0]                  qos_level,
    output logic [mqttd_pkg::LEN_W-1:0] remaining_length,
    output logic                        end_of_packet,
    output logic [15:0]                 packet_id,
    output logic                        packet_id_valid,
    output logic [3:0]                  reply_type,
    output logic [1:0]                  fault_code
);

    logic              push_valid, push_ready;
    logic              pop_valid, pop_ready;
    mqttd_pkg::entry_t push_data, pop_data;

    mqttd_front u_front
    (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    mqttd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mqttd_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_data         (pop_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .data_byte        (data_byte),
        .byte_role        (byte_role),
        .packet_type      (packet_type),
        .qos_level        (qos_level),
        .remaining_length (remaining_length),
        .end_of_packet    (end_of_packet),
        .packet_id        (packet_id),
        .packet_id_valid  (packet_id_valid),
        .reply_type       (reply_type),
        .fault_code       (fault_code)
    );

endmodule

// File: rtl/mqttd_checker.sv
// Port-level assertions for the MQTT receive deframer, and their bind.
// Depends on mqttd_pkg; attaches to mqtt_rx_packet_deframer_unit.
module mqttd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  data_byte,
    input logic [2:0]  byte_role,
    input logic [3:0]  packet_type,
    input logic [1:0]  qos_level,
    input logic        end_of_packet,
    input logic [15:0] packet_id,
    input logic        packet_id_valid,
    input logic [3:0]  reply_type,
    input logic [1:0]  fault_code
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(byte_role))
        else $error("stalled result changed");

    // Discarded bytes carry no packet information
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_role == mqttd_pkg::ROLE_DISCARD |->
        packet_type == mqttd_pkg::PKT_NONE && qos_level == 2'd0 && !end_of_packet &&
        !packet_id_valid && reply_type == mqttd_pkg::PKT_NONE &&
        fault_code == mqttd_pkg::ERR_NONE)
        else $error("discarded byte has fields set");

    // After an error only discarded bytes follow
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && fault_code != mqttd_pkg::ERR_NONE |=>
        !out_valid || byte_role == mqttd_pkg::ROLE_DISCARD)
        else $error("byte parsed after an error");

    // A reply is owed only at a clean packet end
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_type != mqttd_pkg::PKT_NONE |->
        end_of_packet && fault_code == mqttd_pkg::ERR_NONE)
        else $error("reply outside a clean packet end");

    // Identifier reads zero until complete
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !packet_id_valid |-> packet_id == 16'd0)
        else $error("identifier shown before complete");

endmodule

bind mqtt_rx_packet_deframer_unit mqttd_checker u_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .data_byte       (data_byte),
    .byte_role       (byte_role),
    .packet_type     (packet_type),
    .qos_level       (qos_level),
    .end_of_packet   (end_of_packet),
    .packet_id       (packet_id),
    .packet_id_valid (packet_id_valid),
    .reply_type      (reply_type),
    .fault_code      (fault_code)
);
